// File: rtl/twrtc_pkg.sv
package twrtc_pkg;

  localparam int BITS_PER_BYTE = 8;

  // step counts of the transaction phases
  localparam logic [5:0] TX_READ_STEPS  = 6'(2 * BITS_PER_BYTE);
  localparam logic [5:0] TX_WRITE_STEPS = 6'(4 * BITS_PER_BYTE);
  localparam logic [5:0] RX_END_STEP    = 6'(4 * BITS_PER_BYTE - 1);

  localparam logic [6:0] BCD_MAX = 7'd99;

  // action codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;

  typedef struct packed {
    logic        active;
    logic        reading;
    logic [5:0]  step;
    logic [15:0] tx_shift;
    logic [7:0]  rx_shift;
  } state_t;

  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       data_out;
    logic       data_drive;
    logic       busy;
    logic       done;
    logic [7:0] read_value;
  } result_t;

  // clamp at 99, tens by multiply with reciprocal (exact below 180)
  function automatic logic [7:0] to_bcd(input logic [6:0] dec);
    logic [6:0]  v;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    v    = (dec > BCD_MAX) ? BCD_MAX : dec;
    prod = v * 8'd205;
    tens = prod[14:11];
    ones = v - ({3'b000, tens} << 3) - ({3'b000, tens} << 1);
    return {tens, ones[3:0]};
  endfunction

  // high nibble times ten plus low nibble, at most 165
  function automatic logic [7:0] from_bcd(input logic [7:0] bcd);
    logic [7:0] hi;
    hi = {4'b0000, bcd[7:4]};
    return (hi << 3) + (hi << 1) + {4'b0000, bcd[3:0]};
  endfunction

endpackage

// File: rtl/three_wire_rtc_serial_master_core.sv
// Three-wire serial master for a real-time-clock chip. Every accepted item
// yields exactly one result item carrying the pin levels for that moment.
// A start-read or start-write item on an idle block raises chip enable;
// each tick item after that moves the link by half a serial clock. A write
// sends the command byte and then the value (clamped at 99) as BCD, LSB
// first; a read sends address plus one, releases the data line, samples
// eight bits and on the last tick reports the byte converted from BCD.
// Requests while busy, ticks while idle and action code three do nothing.
// Rate: one item per clock cycle while the result channel does not stall. An
// input register takes the item, then the sequence state and the result
// register are updated together in a single pass. The result register
// holds a finished item while the input register takes the next one.
module three_wire_rtc_serial_master_core import twrtc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] action_i,
  input  logic [7:0] address_i,
  input  logic [6:0] write_value_i,
  input  logic       io_sample_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       chip_enable_o,
  output logic       serial_clock_o,
  output logic       data_out_o,
  output logic       data_drive_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic [7:0] read_value_o
);

  // input register
  logic       in_valid_q;
  logic [1:0] action_q;
  logic [7:0] address_q;
  logic [6:0] write_value_q;
  logic       io_sample_q;

  // sequence state and result register
  state_t     state_q, state_d;
  result_t    res_q, res_d;
  logic       out_valid_q;

  logic       out_free;
  logic       advance;

  // result register can take a new item when empty or being drained
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  twrtc_step u_step (
    .action_i      (action_q),
    .address_i     (address_q),
    .write_value_i (write_value_q),
    .io_sample_i   (io_sample_q),
    .state_i       (state_q),
    .state_o       (state_d),
    .res_o         (res_d)
  );

  // control and sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      action_q      <= action_i;
      address_q     <= address_i;
      write_value_q <= write_value_i;
      io_sample_q   <= io_sample_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign chip_enable_o  = res_q.chip_enable;
  assign serial_clock_o = res_q.serial_clock;
  assign data_out_o     = res_q.data_out;
  assign data_drive_o   = res_q.data_drive;
  assign busy_res_o     = res_q.busy;
  assign done_res_o     = res_q.done;
  assign read_value_o   = res_q.read_value;

  // the step counter never runs past the final tick of a write transaction
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.step <= TX_WRITE_STEPS)
    else $error("step counter out of range");

  // the ending item releases every pin and clears busy
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o && !chip_enable_o && !data_drive_o)
    else $error("done item with pins still active");

  // a received value only appears with done
  a_value_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> read_value_o == 8'd0)
    else $error("read value outside done item");

  // the data line is only driven inside a transaction
  a_drive_ce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && data_drive_o |-> chip_enable_o && busy_res_o)
    else $error("data driven without chip enable");

endmodule

// File: rtl/twrtc_step.sv
module twrtc_step import twrtc_pkg::*; (
  input  logic [1:0] action_i,
  input  logic [7:0] address_i,
  input  logic [6:0] write_value_i,
  input  logic       io_sample_i,
  input  state_t     state_i,
  output state_t     state_o,
  output result_t    res_o
);

  logic [5:0] tx_len;
  logic [7:0] addr_inc;
  logic [2:0] rx_idx;

  assign tx_len   = state_i.reading ? TX_READ_STEPS : TX_WRITE_STEPS;
  assign addr_inc = address_i + 8'd1;
  assign rx_idx   = state_i.step[3:1];

  always_comb begin
    state_o = state_i;
    res_o   = '0;
    if (!state_i.active) begin
      if (action_i == ACT_READ || action_i == ACT_WRITE) begin
        state_o.active   = 1'b1;
        state_o.reading  = (action_i == ACT_READ);
        state_o.step     = '0;
        state_o.rx_shift = '0;
        state_o.tx_shift = (action_i == ACT_READ) ? {8'h00, addr_inc}
                                                  : {to_bcd(write_value_i), address_i};
        res_o.chip_enable = 1'b1;
        res_o.data_drive  = 1'b1;
      end
    end else if (action_i == ACT_TICK) begin
      if (state_i.step < tx_len) begin
        // send phase: data with sclk low, then sclk high
        res_o.chip_enable  = 1'b1;
        res_o.data_drive   = 1'b1;
        res_o.data_out     = state_i.tx_shift[state_i.step[4:1]];
        res_o.serial_clock = state_i.step[0];
        state_o.step       = state_i.step + 6'd1;
      end else if (state_i.reading && state_i.step < RX_END_STEP) begin
        // receive phase: sample on even steps, pulse on odd steps
        res_o.chip_enable = 1'b1;
        if (!state_i.step[0]) begin
          if (io_sample_i) begin
            state_o.rx_shift[rx_idx] = 1'b1;
          end
        end else begin
          res_o.serial_clock = 1'b1;
        end
        state_o.step = state_i.step + 6'd1;
      end else begin
        res_o.done       = 1'b1;
        res_o.read_value = state_i.reading ? from_bcd(state_i.rx_shift) : 8'd0;
        state_o.active   = 1'b0;
        state_o.reading  = 1'b0;
        state_o.step     = '0;
      end
    end
    res_o.busy = state_o.active;
  end

endmodule

// File: verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import twrtc_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  localparam int IDLE_LIMIT   = 1000;   // cycles with no handshake on either side
  localparam int DRAIN_AT_TXN = 15;     // random transaction after which the source waits

  // one directed stimulus line; want is only used when typed is set
  typedef struct {
    logic [1:0] act;
    logic [7:0] addr;
    logic [6:0] wval;
    logic       io;
    int         reps;
    bit         typed;
    result_t    want;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] action_i;
  logic [7:0] address_i;
  logic [6:0] write_value_i;
  logic       io_sample_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       chip_enable_o;
  logic       serial_clock_o;
  logic       data_out_o;
  logic       data_drive_o;
  logic       busy_res_o;
  logic       done_res_o;
  logic [7:0] read_value_o;

  // link state as the checker sees it
  logic        link_active;
  logic        link_reading;
  logic [5:0]  link_step;
  logic [15:0] link_tx;
  logic [7:0]  link_rx;
  logic [7:0]  link_last;

  result_t   pins_expected[$];
  stim_row_t dir_rows[$];

  int items_sent;
  int dir_items;
  int rand_items;
  int txn_count;
  int results_checked;
  int mismatches;
  int reads_done;
  int writes_done;
  int idle_cycles;
  bit src_calm;
  bit sink_calm;
  int sink_hold;
  int sink_cycle;

  three_wire_rtc_serial_master_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .address_i      (address_i),
    .write_value_i  (write_value_i),
    .io_sample_i    (io_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .chip_enable_o  (chip_enable_o),
    .serial_clock_o (serial_clock_o),
    .data_out_o     (data_out_o),
    .data_drive_o   (data_drive_o),
    .busy_res_o     (busy_res_o),
    .done_res_o     (done_res_o),
    .read_value_o   (read_value_o)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic result_t pins(input logic ce, input logic sclk, input logic dout,
                                    input logic drive, input logic busy, input logic done,
                                    input logic [7:0] rv);
    result_t r;
    r.chip_enable  = ce;
    r.serial_clock = sclk;
    r.data_out     = dout;
    r.data_drive   = drive;
    r.busy         = busy;
    r.done         = done;
    r.read_value   = rv;
    return r;
  endfunction

  // pin levels for one accepted item; advances the link state
  function automatic result_t rtc_link_step(input logic [1:0] act, input logic [7:0] addr,
                                            input logic [6:0] wval, input logic io);
    result_t r;
    int      s;
    int      send_len;
    int      k;
    int      v;
    r = '0;
    if (!link_active) begin
      // only a request wakes an idle link
      if (act == ACT_READ || act == ACT_WRITE) begin
        link_active  = 1'b1;
        link_reading = (act == ACT_READ);
        link_step    = '0;
        link_rx      = '0;
        if (link_reading) begin
          link_tx = {8'h00, 8'(addr + 8'd1)};
        end else begin
          // clamp at 99, then tens and ones digits side by side
          v       = (wval > 7'd99) ? 99 : int'(wval);
          link_tx = {4'(v / 10), 4'(v % 10), addr};
        end
        r.chip_enable = 1'b1;
        r.data_drive  = 1'b1;
      end
    end else if (act == ACT_TICK) begin
      s        = int'(link_step);
      send_len = link_reading ? 2 * BITS_PER_BYTE : 4 * BITS_PER_BYTE;
      if (s < send_len) begin
        // send phase: data with sclk low, then sclk high
        r.chip_enable  = 1'b1;
        r.data_drive   = 1'b1;
        r.data_out     = link_tx[s / 2];
        r.serial_clock = s[0];
        link_step      = 6'(s + 1);
      end else if (link_reading && s < send_len + 2 * BITS_PER_BYTE - 1) begin
        // receive phase: sample on even steps, pulse on odd ones
        k             = s - send_len;
        r.chip_enable = 1'b1;
        if (k % 2 == 0) begin
          if (io) begin
            link_rx[k / 2] = 1'b1;
          end
        end else begin
          r.serial_clock = 1'b1;
        end
        link_step = 6'(s + 1);
      end else begin
        // final tick: release everything and report
        if (link_reading) begin
          link_last = 8'(int'(link_rx[7:4]) * 10 + int'(link_rx[3:0]));
          reads_done++;
        end else begin
          link_last = '0;
          writes_done++;
        end
        r.done       = 1'b1;
        r.read_value = link_last;
        link_active  = 1'b0;
        link_reading = 1'b0;
        link_step    = '0;
      end
    end
    r.busy = link_active;
    return r;
  endfunction

  task automatic add_row(input logic [1:0] act, input logic [7:0] addr, input logic [6:0] wval,
                         input logic io, input int reps, input bit typed, input result_t want);
    stim_row_t row;
    row.act   = act;
    row.addr  = addr;
    row.wval  = wval;
    row.io    = io;
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  // drive one item, wait for its handshake and record what must come back;
  // returns on the falling edge after acceptance
  task automatic send_item(input logic [1:0] act, input logic [7:0] addr, input logic [6:0] wval,
                           input logic io, input bit typed, input result_t want);
    int      gap;
    int      p;
    result_t pred;
    gap = 0;
    if (!src_calm) begin
      // mostly back to back, some short gaps, a few long ones
      p = $urandom_range(0, 99);
      if (p >= 95) begin
        gap = $urandom_range(8, 40);
      end else if (p >= 70) begin
        gap = $urandom_range(1, 3);
      end
    end
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    address_i     <= addr;
    write_value_i <= wval;
    io_sample_i   <= io;
    do @(posedge clk_i); while (in_stall_o);
    pred = rtc_link_step(act, addr, wval, io);
    pins_expected.push_back(typed ? want : pred);
    items_sent++;
    @(negedge clk_i);
  endtask

  // random items from the given lowest action code up; from ACT_READ up they change nothing in a busy link
  task automatic send_noise(input int count, input logic [1:0] lowest);
    repeat (count) begin
      send_item(2'($urandom_range(lowest, ACT_NOP)), 8'($urandom_range(0, 255)),
                7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)), 1'b0, '0);
    end
  endtask

  // source holds off until every result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pins_expected.size() != 0);
  endtask

  // one complete read or write with random content, now and then broken
  // up by requests and no-ops that a busy link must ignore
  task automatic run_transaction();
    logic [1:0] req;
    logic [7:0] addr;
    logic [6:0] wval;
    int         ticks;
    req = ($urandom_range(0, 1) == 1) ? ACT_READ : ACT_WRITE;
    if ($urandom_range(0, 4) == 0) begin
      addr = ($urandom_range(0, 1) == 1) ? 8'hff : 8'h00;
    end else begin
      addr = 8'($urandom_range(0, 255));
    end
    case ($urandom_range(0, 5))
      0: begin
        wval = 7'd99;
      end
      1: begin
        wval = 7'd100;
      end
      2: begin
        wval = 7'($urandom_range(100, 127));
      end
      default: begin
        wval = 7'($urandom_range(0, 127));
      end
    endcase
    send_item(req, addr, wval, 1'($urandom_range(0, 1)), 1'b0, '0);
    // read: 16 send + 15 receive + final, write: 32 send + final
    ticks = (req == ACT_READ) ? 4 * BITS_PER_BYTE : 4 * BITS_PER_BYTE + 1;
    repeat (ticks) begin
      if ($urandom_range(0, 19) == 0) begin
        send_noise($urandom_range(1, 3), ACT_READ);
      end
      send_item(ACT_TICK, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                1'($urandom_range(0, 1)), 1'b0, '0);
    end
    rand_items += ticks + 1;
  endtask

  // sink stall: random holds, some long, with calm stretches in between
  always @(negedge clk_i) begin
    if (rst_ni) begin
      sink_cycle++;
      if (sink_cycle % 256 == 0) begin
        sink_calm = ($urandom_range(0, 3) == 0);
      end
      if (sink_hold == 0 && !sink_calm) begin
        if ($urandom_range(0, 99) < 3) begin
          sink_hold = $urandom_range(10, 40);
        end else if ($urandom_range(0, 99) < 20) begin
          sink_hold = $urandom_range(1, 3);
        end
      end
      out_stall_i <= (sink_hold != 0);
      if (sink_hold != 0) begin
        sink_hold--;
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // compare every accepted result with the oldest expectation
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {chip_enable_o, serial_clock_o, data_out_o, data_drive_o,
             busy_res_o, done_res_o, read_value_o};
      if (pins_expected.size() == 0) begin
        $error("result item with nothing expected");
        mismatches++;
      end else begin
        want = pins_expected.pop_front();
        check_field("chip_enable", want.chip_enable, got.chip_enable);
        check_field("serial_clock", want.serial_clock, got.serial_clock);
        check_field("data_out", want.data_out, got.data_out);
        check_field("data_drive", want.data_drive, got.data_drive);
        check_field("busy_res", want.busy, got.busy);
        check_field("done_res", want.done, got.done);
        check_field("read_value", want.read_value, got.read_value);
      end
      results_checked++;
    end
  end

  // watchdog: the run is stuck when neither side moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $error("no handshake for %0d cycles, %0d results outstanding",
               idle_cycles, pins_expected.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    action_i      = ACT_TICK;
    address_i     = '0;
    write_value_i = '0;
    io_sample_i   = 1'b0;
    out_stall_i   = 1'b0;
    link_active   = 1'b0;
    link_reading  = 1'b0;
    link_step     = '0;
    link_tx       = '0;
    link_rx       = '0;
    link_last     = '0;
    src_calm      = 1'b1;
    sink_calm     = 1'b1;

    // directed table; typed rows carry the pins read straight off the spec
    // idle link: ticks and no-ops give all zeros
    add_row(ACT_TICK, 8'h00, 7'd0, 1'b0, 1, 1'b1, pins(0, 0, 0, 0, 0, 0, 8'd0));
    add_row(ACT_NOP, 8'hff, 7'd127, 1'b1, 1, 1'b1, pins(0, 0, 0, 0, 0, 0, 8'd0));
    // write with value above 99, clamped
    add_row(ACT_WRITE, 8'hff, 7'd127, 1'b0, 1, 1'b1, pins(1, 0, 0, 1, 1, 0, 8'd0));
    // requests and no-ops while busy are ignored
    add_row(ACT_READ, 8'h12, 7'd5, 1'b1, 1, 1'b1, pins(0, 0, 0, 0, 1, 0, 8'd0));
    add_row(ACT_WRITE, 8'h34, 7'd6, 1'b0, 1, 1'b1, pins(0, 0, 0, 0, 1, 0, 8'd0));
    add_row(ACT_NOP, 8'h56, 7'd7, 1'b1, 1, 1'b1, pins(0, 0, 0, 0, 1, 0, 8'd0));
    add_row(ACT_TICK, 8'h00, 7'd0, 1'b0, 32, 1'b0, '0);
    add_row(ACT_TICK, 8'h00, 7'd0, 1'b0, 1, 1'b1, pins(0, 0, 0, 0, 0, 1, 8'd0));
    // read at 0xff sends 0x00; all ones on the line gives 165
    add_row(ACT_READ, 8'hff, 7'd0, 1'b0, 1, 1'b1, pins(1, 0, 0, 1, 1, 0, 8'd0));
    add_row(ACT_TICK, 8'h00, 7'd0, 1'b1, 31, 1'b0, '0);
    add_row(ACT_TICK, 8'h00, 7'd0, 1'b1, 1, 1'b1, pins(0, 0, 0, 0, 0, 1, 8'd165));
    // read at 0x00 with the line low gives 0
    add_row(ACT_READ, 8'h00, 7'd0, 1'b1, 1, 1'b1, pins(1, 0, 0, 1, 1, 0, 8'd0));
    add_row(ACT_TICK, 8'hff, 7'd127, 1'b0, 31, 1'b0, '0);
    add_row(ACT_TICK, 8'h00, 7'd0, 1'b0, 1, 1'b1, pins(0, 0, 0, 0, 0, 1, 8'd0));
    // write of zero at address zero
    add_row(ACT_WRITE, 8'h00, 7'd0, 1'b0, 1, 1'b1, pins(1, 0, 0, 1, 1, 0, 8'd0));
    add_row(ACT_TICK, 8'h00, 7'd0, 1'b0, 33, 1'b0, '0);
    // write exactly at the clamp, line level ignored while sending
    add_row(ACT_WRITE, 8'h8e, 7'd99, 1'b1, 1, 1'b1, pins(1, 0, 0, 1, 1, 0, 8'd0));
    add_row(ACT_TICK, 8'h00, 7'd0, 1'b1, 33, 1'b0, '0);
    // just above the clamp
    add_row(ACT_WRITE, 8'h55, 7'd100, 1'b0, 1, 1'b1, pins(1, 0, 0, 1, 1, 0, 8'd0));
    add_row(ACT_TICK, 8'haa, 7'd42, 1'b0, 33, 1'b0, '0);
    // read with ordinary address, then a tick on the idle link
    add_row(ACT_READ, 8'h3a, 7'd0, 1'b0, 1, 1'b1, pins(1, 0, 0, 1, 1, 0, 8'd0));
    add_row(ACT_TICK, 8'h00, 7'd0, 1'b1, 32, 1'b0, '0);
    add_row(ACT_TICK, 8'h00, 7'd0, 1'b1, 1, 1'b1, pins(0, 0, 0, 0, 0, 0, 8'd0));

    // reset held low at the start, released once
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, back to back
    foreach (dir_rows[i]) begin
      repeat (dir_rows[i].reps) begin
        send_item(dir_rows[i].act, dir_rows[i].addr, dir_rows[i].wval, dir_rows[i].io,
                  dir_rows[i].typed, dir_rows[i].want);
      end
    end
    dir_items = items_sent;
    drain();

    // random part: mostly whole transactions, some loose noise in between
    while (rand_items < RANDOM_ITEMS) begin
      src_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        send_noise($urandom_range(1, 4), ACT_TICK);
      end
      run_transaction();
      txn_count++;
      if (txn_count == DRAIN_AT_TXN) begin
        drain();
      end
    end
    in_valid_i <= 1'b0;

    // wait for the tail, then keep the clock running to catch anything stray
    while (pins_expected.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("drove %0d items (%0d directed, %0d random transactions), checked %0d results",
             items_sent, dir_items, txn_count, results_checked);
    $display("completed %0d reads and %0d writes, %0d mismatches",
             reads_done, writes_done, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
